[design/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Types, codes and shape helpers shared by the buddy allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Node status bits.
    localparam logic [2:0] ST_LEFT  = 3'b001;
    localparam logic [2:0] ST_RIGHT = 3'b010;
    localparam logic [2:0] ST_FREE  = 3'b100;
    localparam logic [2:0] ST_ALL   = 3'b111;

    localparam int MAX_HEIGHT = 21;

    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] request_size;
        logic [6:0]  node_index;
    } t_in_item;

    typedef struct packed {
        logic        success;
        logic [6:0]  granted_node;
        logic [9:0]  block_offset;
        logic [10:0] block_size;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_A_RD, S_A_EV, S_A_UP, S_A_PEV,
        S_F_SIB, S_F_SIBW, S_F_PAR, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_CLEAR, DP_FREE_INIT, DP_ALLOC_INIT, DP_READ_NODE,
        DP_EVAL_FAIL, DP_GRANT, DP_DESCEND_L, DP_UP, DP_MERGE_A,
        DP_SIB_RD, DP_PAR_RD, DP_MERGE_F
    } t_dp_op;

    typedef struct packed {
        logic is_alloc;
        logic is_free;
        logic is_clear;
        logic idx_ok;
        logic req_ok;
        logic s_zero;
        logic s_term;
        logic s_free;
        logic at_root;
        logic ret_ok;
        logic child_left;
    } t_dp_stat;

    // Largest level whose blocks still hold at least min_blk units.
    function automatic int tree_height(input int max_blk, input int min_blk);
        int h;
        h = 0;
        for (int k = 1; k < MAX_HEIGHT; k++) begin
            if ((max_blk >> k) >= min_blk && h == k - 1) begin
                h = k;
            end
        end
        return h;
    endfunction

endpackage

[design/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 127
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

[design/bba_datapath.sv]
// ----------------------------------------------------------------------------
// bba_datapath
// Node status store, walk registers and result formation for the allocator.
// ----------------------------------------------------------------------------
module bba_datapath import bba_pkg::*; #(
    parameter int MAX_BLOCK = 1024,
    parameter int H         = 6
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_op    i_op,
    input  t_in_item  i_item,
    output t_dp_stat  o_stat,
    output t_out_item o_res
);
    localparam int NODES = (1 << (H + 1)) - 1;
    localparam int NW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW    = (H > 0) ? $clog2(H + 1) : 1;

    logic [1:0]    r_cmd;
    logic [10:0]   r_req,  n_req;
    logic [6:0]    r_idx;
    logic [NW-1:0] r_node, n_node;
    logic [LW-1:0] r_lvl,  n_lvl;
    logic          r_ret_ok, n_ret_ok, r_ret_zero, n_ret_zero;
    logic          r_child_left, n_child_left;
    logic [2:0]    r_cur, n_cur, r_sib, n_sib;
    logic [NODES-1:0] r_vld, n_vld;
    logic          r_rd_vld;
    t_out_item     r_res, n_res;

    logic          we;
    logic [NW-1:0] waddr, raddr;
    logic [2:0]    wdata, ram_q, s_eff, merge;
    logic [NW-1:0] parent, lchild, sibling;
    logic [31:0]   half, pos32, size32, node32;
    logic [19:0]   prod;

    bba_ram #(.WIDTH(3), .DEPTH(NODES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(ram_q)
    );

    // An entry never written since reset or clear reads as wholly free.
    assign s_eff   = r_rd_vld ? ram_q : ST_ALL;
    assign parent  = NW'((r_node - NW'(1)) >> 1);
    assign lchild  = NW'({r_node, 1'b1});
    assign sibling = r_node[0] ? r_node + NW'(1) : r_node - NW'(1);
    assign half    = 32'(MAX_BLOCK) >> (32'(r_lvl) + 32'd1);
    assign size32  = 32'(MAX_BLOCK) >> r_lvl;
    assign pos32   = 32'(r_node) + 32'd1 - (32'd1 << r_lvl);
    assign node32  = 32'(r_node);
    assign prod    = pos32[9:0] * size32[9:0];

    always_comb begin
        o_stat.is_alloc   = (r_cmd == CMD_ALLOC);
        o_stat.is_free    = (r_cmd == CMD_FREE);
        o_stat.is_clear   = (r_cmd == CMD_CLEAR);
        o_stat.idx_ok     = (32'(r_idx) < 32'(NODES));
        o_stat.req_ok     = (32'(r_req) <= 32'(MAX_BLOCK));
        o_stat.s_zero     = (s_eff == 3'b000);
        o_stat.s_term     = (half < 32'(r_req)) || (32'(r_lvl) >= 32'(H));
        o_stat.s_free     = |(s_eff & ST_FREE);
        o_stat.at_root    = (r_node == '0);
        o_stat.ret_ok     = r_ret_ok;
        o_stat.child_left = r_child_left;
    end

    always_comb begin
        n_req = r_req; n_node = r_node; n_lvl = r_lvl;
        n_ret_ok = r_ret_ok; n_ret_zero = r_ret_zero; n_child_left = r_child_left;
        n_cur = r_cur; n_sib = r_sib; n_vld = r_vld; n_res = r_res;
        we = 1'b0; waddr = r_node; wdata = 3'b000; raddr = r_node;
        merge = s_eff;
        unique case (i_op)
            DP_NOP: begin
            end
            DP_LOAD: begin
                n_req = (i_item.request_size == 11'd0) ? 11'd1 : i_item.request_size;
                n_res = '0;
            end
            DP_CLEAR: begin
                n_vld = '0;
                n_res.success = 1'b1;
            end
            DP_FREE_INIT: begin
                n_node = NW'(r_idx);
                we = 1'b1; waddr = NW'(r_idx); wdata = ST_ALL;
                n_vld[NW'(r_idx)] = 1'b1;
                n_cur = ST_ALL;
                n_res.success = 1'b1;
            end
            DP_ALLOC_INIT: begin
                n_node = '0; n_lvl = '0;
            end
            DP_READ_NODE: begin
                raddr = r_node;
            end
            DP_EVAL_FAIL: begin
                n_ret_ok = 1'b0;
                n_ret_zero = (s_eff == 3'b000);
            end
            DP_GRANT: begin
                we = 1'b1; waddr = r_node; wdata = 3'b000;
                n_vld[r_node] = 1'b1;
                n_ret_ok = 1'b1; n_ret_zero = 1'b1;
                n_res.success      = 1'b1;
                n_res.granted_node = node32[6:0];
                n_res.block_offset = prod[9:0];
                n_res.block_size   = size32[10:0];
            end
            DP_DESCEND_L: begin
                n_node = lchild; n_lvl = r_lvl + LW'(1);
            end
            DP_UP: begin
                n_child_left = r_node[0];
                n_node = parent; n_lvl = r_lvl - LW'(1);
                raddr = parent;
            end
            DP_MERGE_A: begin
                if (r_ret_zero) begin
                    merge = merge & ~(r_child_left ? ST_LEFT : ST_RIGHT);
                end
                if (r_ret_ok) begin
                    merge = merge & ~ST_FREE;
                end
                we = 1'b1; waddr = r_node; wdata = merge;
                n_vld[r_node] = 1'b1;
                n_ret_zero = (merge == 3'b000);
                if (!r_ret_ok && r_child_left) begin
                    n_node = lchild + NW'(1); n_lvl = r_lvl + LW'(1);
                end
            end
            DP_SIB_RD: begin
                raddr = sibling;
            end
            DP_PAR_RD: begin
                n_sib = s_eff;
                raddr = parent;
            end
            DP_MERGE_F: begin
                merge = s_eff | (r_node[0] ? ST_LEFT : ST_RIGHT);
                if (r_cur[2] && r_sib[2]) begin
                    merge = merge | ST_FREE;
                end
                we = 1'b1; waddr = parent; wdata = merge;
                n_vld[parent] = 1'b1;
                n_cur = merge; n_node = parent;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_vld    <= n_vld;
            r_rd_vld <= r_vld[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_LOAD) begin
            r_cmd <= i_item.command;
            r_idx <= i_item.node_index;
        end
        r_req <= n_req; r_node <= n_node; r_lvl <= n_lvl;
        r_ret_ok <= n_ret_ok; r_ret_zero <= n_ret_zero; r_child_left <= n_child_left;
        r_cur <= n_cur; r_sib <= n_sib; r_res <= n_res;
    end

    assign o_res = r_res;
endmodule

[design/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate, free and clear commands of the buddy allocator.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_busy,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_load,
    output t_dp_op   o_op
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = DP_NOP;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                priority if (i_stat.is_clear) begin
                    o_op = DP_CLEAR;
                end else if (i_stat.is_free && i_stat.idx_ok) begin
                    o_op = DP_FREE_INIT;
                    n_state = S_F_SIB;
                end else if (i_stat.is_alloc && i_stat.req_ok) begin
                    o_op = DP_ALLOC_INIT;
                    n_state = S_A_RD;
                end else begin
                    o_op = DP_NOP;
                end
            end
            S_A_RD: begin
                o_op = DP_READ_NODE;
                n_state = S_A_EV;
            end
            S_A_EV: begin
                n_state = S_A_UP;
                priority if (i_stat.s_zero) begin
                    o_op = DP_EVAL_FAIL;
                end else if (i_stat.s_term) begin
                    o_op = i_stat.s_free ? DP_GRANT : DP_EVAL_FAIL;
                end else begin
                    o_op = DP_DESCEND_L;
                    n_state = S_A_RD;
                end
            end
            S_A_UP: begin
                if (i_stat.at_root) begin
                    n_state = S_DONE;
                end else begin
                    o_op = DP_UP;
                    n_state = S_A_PEV;
                end
            end
            S_A_PEV: begin
                o_op = DP_MERGE_A;
                n_state = (!i_stat.ret_ok && i_stat.child_left) ? S_A_RD : S_A_UP;
            end
            S_F_SIB: begin
                if (i_stat.at_root) begin
                    n_state = S_DONE;
                end else begin
                    o_op = DP_SIB_RD;
                    n_state = S_F_SIBW;
                end
            end
            S_F_SIBW: begin
                o_op = DP_PAR_RD;
                n_state = S_F_PAR;
            end
            S_F_PAR: begin
                o_op = DP_MERGE_F;
                n_state = S_F_SIB;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[design/buddy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Binary buddy allocator: allocate, free and clear over a tree of node status.
// ----------------------------------------------------------------------------
// Flow: a clear or rejected command goes from decode to the done state, which
// loads the output register once it is free; the next item is taken after that.
// An allocate reads and checks each node going down and merges each level back
// up, bounded by the one-read-port status RAM; a free reads sibling and parent
// per level from the node to the root. One item is in flight at a time.
// Reset marks every block free at once through per-node valid bits.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int MAX_BLOCK = 1024,
    parameter int MIN_BLOCK = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);
    // Tree height follows from the buffer size and the smallest leaf.
    localparam int H = tree_height(MAX_BLOCK, MIN_BLOCK);

    t_dp_op    op;
    t_dp_stat  stat;
    t_out_item res;
    logic      out_load;
    logic      out_busy;
    logic      r_out_vld;
    t_out_item r_out;

    // The result register is busy while an item waits and is not taken now.
    assign out_busy = r_out_vld && !i_out_ready;

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_out_busy(out_busy),
        .i_stat    (stat),
        .o_in_ready(o_in_ready),
        .o_out_load(out_load),
        .o_op      (op)
    );

    bba_datapath #(.MAX_BLOCK(MAX_BLOCK), .H(H)) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (op),
        .i_item (i_in),
        .o_stat (stat),
        .o_res  (res)
    );

    // Output register: holds the finished item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // A failed command never reports a block.
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.success |-> o_out.block_size == 11'd0 &&
        o_out.block_offset == 10'd0 && o_out.granted_node == 7'd0)
        else $error("failed result carries block fields");

    // Once an item is taken, no other is taken until its result is formed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item accepted while one is in flight");

    // A result is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> !(o_out_valid && !i_out_ready))
        else $error("pending result overwritten");
endmodule

[test/buddy_block_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_tb
// Regression bench for the buddy allocator core. It drives allocate, free and
// clear commands and checks every result against a predictor of the tree.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_tb;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_MAX   = 1024;
    localparam int TREE_MIN   = 16;
    localparam int TREE_DEPTH = 6;     // deepest level, 16-unit leaves
    localparam int NODE_COUNT = 127;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    buddy_block_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Predicted tree: bit 0 left child has space, bit 1 right, bit 2 whole block free.
    logic [2:0] tree_status [NODE_COUNT];
    t_out_item  expected_grants [$];
    int         mismatch_count;
    int         result_count;
    int         item_count;
    int         grant_count;
    bit         sender_idle_on;
    bit         receiver_idle_on;
    logic [6:0] live_blocks [$];

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    function automatic void tree_clear();
        for (int n = 0; n < NODE_COUNT; n++) begin
            tree_status[n] = ST_ALL;
        end
    endfunction

    // Depth-first search, left before right; returns the node taken or -1.
    function automatic int tree_search(input int n, input int lvl, input int req);
        int blk_units;
        int child;
        int got;
        blk_units = TREE_MAX >> lvl;
        if (n >= NODE_COUNT || tree_status[n] == 3'b000) begin
            return -1;
        end
        if (blk_units / 2 < req || lvl >= TREE_DEPTH) begin
            if (tree_status[n][2]) begin
                tree_status[n] = 3'b000;
                return n;
            end
            return -1;
        end
        for (int side = 0; side < 2; side++) begin
            child = 2 * n + 1 + side;
            got = tree_search(child, lvl + 1, req);
            if (child < NODE_COUNT && tree_status[child] == 3'b000) begin
                tree_status[n][side] = 1'b0;
            end
            if (got >= 0) begin
                tree_status[n][2] = 1'b0;
                return got;
            end
        end
        return -1;
    endfunction

    function automatic void tree_release(input int n);
        int parent;
        int left;
        tree_status[n] = ST_ALL;
        while (n != 0) begin
            parent = (n - 1) / 2;
            left = 2 * parent + 1;
            tree_status[parent][(n - 1) & 1] = 1'b1;
            // Merge only when both halves are wholly free.
            if (tree_status[left][2] && tree_status[left + 1][2]) begin
                tree_status[parent][2] = 1'b1;
            end
            n = parent;
        end
    endfunction

    function automatic t_out_item predict_command(input t_in_item item);
        t_out_item res;
        int req;
        int got;
        int lvl;
        int n1;
        res = '0;
        case (item.command)
            CMD_ALLOC: begin
                req = (item.request_size == 0) ? 1 : int'(item.request_size);
                if (req <= TREE_MAX) begin
                    got = tree_search(0, 0, req);
                    if (got >= 0) begin
                        n1 = got + 1;
                        lvl = $clog2(n1 + 1) - 1;
                        res.success = 1'b1;
                        res.granted_node = 7'(got);
                        res.block_size = 11'(TREE_MAX >> lvl);
                        res.block_offset = 10'((n1 - (1 << lvl)) * (TREE_MAX >> lvl));
                    end
                end
            end
            CMD_FREE: begin
                if (item.node_index < NODE_COUNT) begin
                    tree_release(item.node_index);
                    res.success = 1'b1;
                end
            end
            CMD_CLEAR: begin
                tree_clear();
                res.success = 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Sends one item, predicting its result when it is accepted. Valid stays
    // high into the next call so items can follow back to back.
    task automatic send_command(input logic [1:0] cmd, input int req, input int idx);
        t_in_item item;
        t_out_item res;
        item.command = cmd;
        item.request_size = 11'(req);
        item.node_index = 7'(idx);
        while (sender_idle_on && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        res = predict_command(item);
        expected_grants.push_back(res);
        if (cmd == CMD_ALLOC && res.success) begin
            live_blocks.push_back(res.granted_node);
            grant_count++;
        end
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_grants.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(receiver_idle_on && $urandom_range(99) < 33);
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (expected_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result %p", o_out);
                end
            end else begin
                want = expected_grants.pop_front();
                if (o_out.success !== want.success
                        || o_out.granted_node !== want.granted_node
                        || o_out.block_offset !== want.block_offset
                        || o_out.block_size !== want.block_size) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected %p, got %p", want, o_out);
                    end
                end
            end
        end
    end

    task automatic free_random_live();
        int pick;
        logic [6:0] node;
        pick = $urandom_range(live_blocks.size() - 1);
        node = live_blocks[pick];
        live_blocks.delete(pick);
        send_command(CMD_FREE, $urandom_range(2047), node);
    endtask

    task automatic test_field_extremes();
        send_command(CMD_ALLOC, 1024, 0);
        send_command(CMD_ALLOC, 1, 0);        // tree full: fails
        send_command(CMD_FREE, 0, 0);
        send_command(CMD_ALLOC, 1025, 0);     // oversized
        send_command(CMD_ALLOC, 2047, 127);
        send_command(CMD_ALLOC, 0, 0);        // zero acts as one unit
        send_command(CMD_ALLOC, 16, 0);
        send_command(CMD_ALLOC, 17, 0);
        send_command(CMD_ALLOC, 512, 0);
        send_command(CMD_ALLOC, 513, 0);
        send_command(CMD_FREE, 0, 127);       // out of range
        send_command(CMD_FREE, 0, 126);       // not allocated, done anyway
        send_command(CMD_FREE, 0, 63);
        send_command(CMD_FREE, 0, 2);         // descendants keep marks
        send_command(CMD_UNUSED, 2047, 127);
        send_command(CMD_ALLOC, 256, 0);
        send_command(CMD_ALLOC, 1024, 0);
        send_command(CMD_CLEAR, 1024, 64);
        send_command(CMD_ALLOC, 64, 85);
        send_command(CMD_CLEAR, 0, 0);
        live_blocks.delete();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
                // Mostly small requests so the tree fills deep.
                if ($urandom_range(9) < 7) begin
                    send_command(CMD_ALLOC, $urandom_range(1, 128), $urandom_range(127));
                end else begin
                    send_command(CMD_ALLOC, $urandom_range(2047), $urandom_range(127));
                end
            end else if (roll < 85 && live_blocks.size() != 0) begin
                free_random_live();
            end else if (roll < 93) begin
                send_command(CMD_FREE, $urandom_range(2047), $urandom_range(127));
            end else if (roll < 97) begin
                send_command(CMD_CLEAR, $urandom_range(2047), $urandom_range(127));
                live_blocks.delete();
            end else begin
                send_command(CMD_UNUSED, $urandom_range(2047), $urandom_range(127));
            end
        end
        wait_drained();
    endtask

    initial begin
        mismatch_count = 0;
        result_count = 0;
        item_count = 0;
        grant_count = 0;
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        tree_clear();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_field_extremes();
        test_random_traffic(200);
        sender_idle_on = 1'b0;
        receiver_idle_on = 1'b0;
        test_random_traffic(100);
        sender_idle_on = 1'b1;
        receiver_idle_on = 1'b1;
        test_random_traffic(200);
        $display("Covered %0d commands, %0d results, %0d grants.",
                 item_count, result_count, grant_count);
        if (mismatch_count == 0 && expected_grants.size() == 0) begin
            $display("buddy_block_allocator_core regression: pass");
        end else begin
            $display("buddy_block_allocator_core regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("buddy_block_allocator_core regression: fail");
        $finish;
    end

endmodule

[files.f]
design/bba_pkg.sv
design/bba_ram.sv
design/bba_datapath.sv
design/bba_ctrl.sv
design/buddy_block_allocator_core.sv
test/buddy_block_allocator_core_tb.sv
